>>> rtl/pso_particle_element_update_defines.svh
// Assertion helpers shared by the particle update RTL.
`ifndef PSO_PARTICLE_ELEMENT_UPDATE_DEFINES_SVH
`define PSO_PARTICLE_ELEMENT_UPDATE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define PSO_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define PSO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pso_pkg.sv
package pso_pkg;

  // Number format
  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int RAND_BITS = 16;

  // Register widths
  localparam int MODE_W = 2;
  localparam int WGT_W  = FRAC_BITS + 2;
  localparam int VMX_W  = FRAC_BITS + 1;
  localparam int COEF_W = WGT_W + 1;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = WGT_W;

  // Update modes
  localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLAMP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIXED = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DECAY = 2'd3;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [IDX_W-1:0] REG_INERTIA = 3'd1;
  localparam logic [IDX_W-1:0] REG_FIX_W   = 3'd2;
  localparam logic [IDX_W-1:0] REG_FIX_A   = 3'd3;
  localparam logic [IDX_W-1:0] REG_VMAX    = 3'd4;

  // Acceleration coefficients 1.6 and 1.7, rounded
  localparam logic [COEF_W-1:0] COEF_COG = COEF_W'(((16 << FRAC_BITS) + 5) / 10);
  localparam logic [COEF_W-1:0] COEF_SOC = COEF_W'(((17 << FRAC_BITS) + 5) / 10);
  localparam logic [WGT_W-1:0]  WGT_ONE  = WGT_W'(1 << FRAC_BITS);
  localparam logic [VMX_W-1:0]  VMX_ONE  = VMX_W'(1 << FRAC_BITS);

endpackage

>>> rtl/pso_particle_element_update.sv
// Channel | Handshake              | Beat contents
// in_     | in_valid / in_stall    | position, speed, bests, range, two random fractions
// out_    | out_valid / out_stall  | new speed, new position, moved flag
// cfg_    | cfg_valid / cfg_ready  | register index and write data
//
// Seven register stages, s1 to s7; a beat passes through them in order.
// One beat is taken per cycle while in_stall is low; the multipliers sit in
// stage 2 and stage 3, and the other stages hold adds, compares and muxes.
// A stalled stage holds its beat; empty stages ahead of it still fill.
// Synchronous active-low reset clears the valid bits and sets the configuration registers to their defaults.
// cfg_ready is always high; write registers only while the pipeline is empty.
`include "pso_particle_element_update_defines.svh"

module pso_particle_element_update
  import pso_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [IDX_W-1:0]             cfg_index,
  input  logic [CFG_W-1:0]             cfg_data,
  // input beats
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [WORD_BITS-1:0]  in_position,
  input  logic signed [WORD_BITS-1:0]  in_speed,
  input  logic signed [WORD_BITS-1:0]  in_personal_best,
  input  logic signed [WORD_BITS-1:0]  in_global_best,
  input  logic signed [WORD_BITS-1:0]  in_range_min,
  input  logic signed [WORD_BITS-1:0]  in_range_max,
  input  logic [RAND_BITS-1:0]         in_rand_cognitive,
  input  logic [RAND_BITS-1:0]         in_rand_social,
  // result beats
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [WORD_BITS-1:0]  out_new_speed,
  output logic signed [WORD_BITS-1:0]  out_new_position,
  output logic                         out_moved
);

  localparam int WB   = WORD_BITS;
  localparam int N_ST = 7;
  localparam int PP_W = WB + RAND_BITS;          // |diff| * r
  localparam int PV_W = WB + WGT_W;              // |v| * w
  localparam int PL_W = WB + VMX_W;              // span * vmax
  localparam int TP_W = PP_W + COEF_W;           // |diff| * r * c
  localparam int TM_W = TP_W + 1 - FRAC_BITS - RAND_BITS;
  localparam int TW   = TM_W + 1;                // signed term
  localparam int IM_W = PV_W + 1 - FRAC_BITS;
  localparam int IW   = IM_W + 1;                // signed inertia term
  localparam int LM_W = PL_W + 1 - FRAC_BITS;
  localparam int SW   = TW + 2;                  // sum of three terms

  localparam logic [TP_W:0] HALF_T = (TP_W+1)'(1) << (FRAC_BITS + RAND_BITS - 1);
  localparam logic [PV_W:0] HALF_V = (PV_W+1)'(1) << (FRAC_BITS - 1);
  localparam logic [PL_W:0] HALF_L = (PL_W+1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SUM_MAX = SW'((64'd1 << (WB - 1)) - 64'd1);
  localparam logic signed [SW-1:0] SUM_MIN = -SUM_MAX - SW'(1);
  localparam logic [LM_W-1:0] LIM_MAX = LM_W'((64'd1 << (WB - 1)) - 64'd1);

  // ---------------------------------------------------------------- registers
  logic [MODE_W-1:0] mode_r;
  logic [WGT_W-1:0]  inertia_r;
  logic [WGT_W-1:0]  fix_w_r;
  logic [WGT_W-1:0]  fix_a_r;
  logic [VMX_W-1:0]  vmax_r;

  assign cfg_ready = 1'b1;

  // Write one register per beat; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_PLAIN;
      inertia_r <= WGT_ONE;
      fix_w_r   <= WGT_ONE;
      fix_a_r   <= WGT_ONE;
      vmax_r    <= VMX_ONE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:    mode_r    <= cfg_data[MODE_W-1:0];
        REG_INERTIA: inertia_r <= cfg_data[WGT_W-1:0];
        REG_FIX_W:   fix_w_r   <= cfg_data[WGT_W-1:0];
        REG_FIX_A:   fix_a_r   <= cfg_data[WGT_W-1:0];
        REG_VMAX:    vmax_r    <= cfg_data[VMX_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control
  logic [N_ST-1:0] v_r;
  logic [N_ST-1:0] adv;

  // A stage may load when it is empty or its beat moves on
  always_comb begin
    adv[N_ST-1] = !v_r[N_ST-1] || !out_stall;
    for (int k = N_ST - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < N_ST; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  // Differences as sign and magnitude, weights picked by mode
  logic signed [WB:0]  dp_f, dp_b, dg_f, dg_b, span;
  logic [WB-1:0]       magp_c, magg_c, magv_c;
  logic [COEF_W-1:0]   c1_c, c2_c;
  logic [WGT_W-1:0]    w_c;

  always_comb begin
    dp_f   = {in_personal_best[WB-1], in_personal_best} - {in_position[WB-1], in_position};
    dp_b   = {in_position[WB-1], in_position} - {in_personal_best[WB-1], in_personal_best};
    dg_f   = {in_global_best[WB-1], in_global_best} - {in_position[WB-1], in_position};
    dg_b   = {in_position[WB-1], in_position} - {in_global_best[WB-1], in_global_best};
    span   = {in_range_max[WB-1], in_range_max} - {in_range_min[WB-1], in_range_min};
    magp_c = dp_f[WB] ? dp_b[WB-1:0] : dp_f[WB-1:0];
    magg_c = dg_f[WB] ? dg_b[WB-1:0] : dg_f[WB-1:0];
    magv_c = in_speed[WB-1] ? (~in_speed + WB'(1)) : in_speed;
    c1_c   = COEF_COG;
    c2_c   = COEF_SOC;
    w_c    = WGT_ONE;
    unique case (mode_r)
      MODE_FIXED: begin
        c1_c = {fix_a_r, 1'b0};
        c2_c = {fix_a_r, 1'b0};
        w_c  = fix_w_r;
      end
      MODE_DECAY: w_c = inertia_r;
      default: ;
    endcase
  end

  logic [WB-1:0]             s1_magp_r, s1_magg_r, s1_magv_r, s1_span_r;
  logic                      s1_sgnp_r, s1_sgng_r, s1_sgnv_r, s1_spos_r, s1_clamp_r;
  logic [RAND_BITS-1:0]      s1_r1_r, s1_r2_r;
  logic [COEF_W-1:0]         s1_c1_r, s1_c2_r;
  logic [WGT_W-1:0]          s1_w_r;
  logic signed [WB-1:0]      s1_x_r, s1_lo_r, s1_hi_r;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1_magp_r  <= magp_c;
      s1_magg_r  <= magg_c;
      s1_magv_r  <= magv_c;
      s1_span_r  <= span[WB-1:0];
      s1_sgnp_r  <= dp_f[WB];
      s1_sgng_r  <= dg_f[WB];
      s1_sgnv_r  <= in_speed[WB-1];
      s1_spos_r  <= in_range_max > in_range_min;
      s1_clamp_r <= mode_r == MODE_CLAMP;
      s1_r1_r    <= in_rand_cognitive;
      s1_r2_r    <= in_rand_social;
      s1_c1_r    <= c1_c;
      s1_c2_r    <= c2_c;
      s1_w_r     <= w_c;
      s1_x_r     <= in_position;
      s1_lo_r    <= in_range_min;
      s1_hi_r    <= in_range_max;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Multiply magnitudes by the random fractions, inertia and limit fraction
  logic [PP_W-1:0]      s2_pp_r, s2_pg_r;
  logic [PV_W-1:0]      s2_pv_r;
  logic [PL_W-1:0]      s2_pl_r;
  logic                 s2_sgnp_r, s2_sgng_r, s2_sgnv_r, s2_spos_r, s2_clamp_r;
  logic [COEF_W-1:0]    s2_c1_r, s2_c2_r;
  logic signed [WB-1:0] s2_x_r, s2_lo_r, s2_hi_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s2_pp_r    <= PP_W'(s1_magp_r) * PP_W'(s1_r1_r);
      s2_pg_r    <= PP_W'(s1_magg_r) * PP_W'(s1_r2_r);
      s2_pv_r    <= PV_W'(s1_magv_r) * PV_W'(s1_w_r);
      s2_pl_r    <= PL_W'(s1_span_r) * PL_W'(vmax_r);
      s2_sgnp_r  <= s1_sgnp_r;
      s2_sgng_r  <= s1_sgng_r;
      s2_sgnv_r  <= s1_sgnv_r;
      s2_spos_r  <= s1_spos_r;
      s2_clamp_r <= s1_clamp_r;
      s2_c1_r    <= s1_c1_r;
      s2_c2_r    <= s1_c2_r;
      s2_x_r     <= s1_x_r;
      s2_lo_r    <= s1_lo_r;
      s2_hi_r    <= s1_hi_r;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // Apply the acceleration weights; round the inertia term and the limit
  logic [PV_W:0]        pv_rnd;
  logic [PL_W:0]        pl_rnd;
  logic [IM_W-1:0]      imag_c;
  logic [LM_W-1:0]      lmag_c;
  logic signed [IW-1:0] inert_c;
  logic signed [WB-1:0] lim_c;

  always_comb begin
    pv_rnd  = {1'b0, s2_pv_r} + HALF_V;
    pl_rnd  = {1'b0, s2_pl_r} + HALF_L;
    imag_c  = pv_rnd[PV_W:FRAC_BITS];
    lmag_c  = pl_rnd[PL_W:FRAC_BITS];
    inert_c = s2_sgnv_r ? -$signed({1'b0, imag_c}) : $signed({1'b0, imag_c});
    if (!s2_spos_r) begin
      lim_c = '0;
    end else if (lmag_c > LIM_MAX) begin
      lim_c = $signed(LIM_MAX[WB-1:0]);
    end else begin
      lim_c = $signed(lmag_c[WB-1:0]);
    end
  end

  logic [TP_W-1:0]      s3_tp_r, s3_tg_r;
  logic                 s3_sgnp_r, s3_sgng_r, s3_clamp_r;
  logic signed [IW-1:0] s3_inert_r;
  logic signed [WB-1:0] s3_lim_r, s3_x_r, s3_lo_r, s3_hi_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s3_tp_r    <= TP_W'(s2_pp_r) * TP_W'(s2_c1_r);
      s3_tg_r    <= TP_W'(s2_pg_r) * TP_W'(s2_c2_r);
      s3_sgnp_r  <= s2_sgnp_r;
      s3_sgng_r  <= s2_sgng_r;
      s3_clamp_r <= s2_clamp_r;
      s3_inert_r <= inert_c;
      s3_lim_r   <= lim_c;
      s3_x_r     <= s2_x_r;
      s3_lo_r    <= s2_lo_r;
      s3_hi_r    <= s2_hi_r;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Round both attraction terms, ties away from zero, and restore signs
  logic [TP_W:0]        tp_rnd, tg_rnd;
  logic [TM_W-1:0]      tpm_c, tgm_c;
  logic signed [TW-1:0] t1_c, t2_c;

  always_comb begin
    tp_rnd = {1'b0, s3_tp_r} + HALF_T;
    tg_rnd = {1'b0, s3_tg_r} + HALF_T;
    tpm_c  = tp_rnd[TP_W:FRAC_BITS+RAND_BITS];
    tgm_c  = tg_rnd[TP_W:FRAC_BITS+RAND_BITS];
    t1_c   = s3_sgnp_r ? -$signed({1'b0, tpm_c}) : $signed({1'b0, tpm_c});
    t2_c   = s3_sgng_r ? -$signed({1'b0, tgm_c}) : $signed({1'b0, tgm_c});
  end

  logic signed [TW-1:0] s4_t1_r, s4_t2_r;
  logic signed [IW-1:0] s4_inert_r;
  logic signed [WB-1:0] s4_lim_r, s4_x_r, s4_lo_r, s4_hi_r;
  logic                 s4_clamp_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s4_t1_r    <= t1_c;
      s4_t2_r    <= t2_c;
      s4_inert_r <= s3_inert_r;
      s4_lim_r   <= s3_lim_r;
      s4_clamp_r <= s3_clamp_r;
      s4_x_r     <= s3_x_r;
      s4_lo_r    <= s3_lo_r;
      s4_hi_r    <= s3_hi_r;
    end
  end

  // ---------------------------------------------------------------- stage 5
  // Sum the three terms and saturate to a word
  logic signed [SW-1:0] sum_c;
  logic signed [WB-1:0] nv_c;

  always_comb begin
    sum_c = {{(SW-IW){s4_inert_r[IW-1]}}, s4_inert_r}
          + {{(SW-TW){s4_t1_r[TW-1]}}, s4_t1_r}
          + {{(SW-TW){s4_t2_r[TW-1]}}, s4_t2_r};
    if (sum_c > SUM_MAX) begin
      nv_c = SUM_MAX[WB-1:0];
    end else if (sum_c < SUM_MIN) begin
      nv_c = SUM_MIN[WB-1:0];
    end else begin
      nv_c = sum_c[WB-1:0];
    end
  end

  logic signed [WB-1:0] s5_nv_r, s5_lim_r, s5_x_r, s5_lo_r, s5_hi_r;
  logic                 s5_clamp_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s5_nv_r    <= nv_c;
      s5_lim_r   <= s4_lim_r;
      s5_clamp_r <= s4_clamp_r;
      s5_x_r     <= s4_x_r;
      s5_lo_r    <= s4_lo_r;
      s5_hi_r    <= s4_hi_r;
    end
  end

  // ---------------------------------------------------------------- stage 6
  // Clamp the velocity symmetrically in clamp mode
  logic signed [WB-1:0] nvc_c;

  always_comb begin
    nvc_c = s5_nv_r;
    if (s5_clamp_r) begin
      if (s5_nv_r > s5_lim_r) begin
        nvc_c = s5_lim_r;
      end else if (s5_nv_r < -s5_lim_r) begin
        nvc_c = -s5_lim_r;
      end
    end
  end

  logic signed [WB-1:0] s6_nv_r, s6_lim_r, s6_x_r, s6_lo_r, s6_hi_r;
  logic                 s6_clamp_r;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s6_nv_r    <= nvc_c;
      s6_lim_r   <= s5_lim_r;
      s6_clamp_r <= s5_clamp_r;
      s6_x_r     <= s5_x_r;
      s6_lo_r    <= s5_lo_r;
      s6_hi_r    <= s5_hi_r;
    end
  end

  // ---------------------------------------------------------------- stage 7
  // Move the particle if it stays within the range, else hold its place
  logic signed [WB:0] np_c;
  logic               in_range_c;

  always_comb begin
    np_c       = {s6_x_r[WB-1], s6_x_r} + {s6_nv_r[WB-1], s6_nv_r};
    in_range_c = (np_c >= $signed({s6_lo_r[WB-1], s6_lo_r}))
              && (np_c <= $signed({s6_hi_r[WB-1], s6_hi_r}));
  end

  logic signed [WB-1:0] s7_nv_r, s7_np_r;
  logic                 s7_moved_r;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s7_nv_r    <= s6_nv_r;
      s7_np_r    <= in_range_c ? np_c[WB-1:0] : s6_x_r;
      s7_moved_r <= in_range_c;
    end
  end

  assign out_valid        = v_r[N_ST-1];
  assign out_new_speed    = s7_nv_r;
  assign out_new_position = s7_np_r;
  assign out_moved        = s7_moved_r;

  // ---------------------------------------------------------------- checks
  `PSO_ASSERT_SAME(a_empty_out_takes, !out_valid, !in_stall, "input stalled with empty output stage")
  `PSO_ASSERT_NEXT(a_no_drop, v_r[N_ST-2] && adv[N_ST-1], out_valid, "beat lost before output stage")
  `PSO_ASSERT_SAME(a_lim_pos, v_r[3], !s4_lim_r[WB-1], "velocity limit negative")
  `PSO_ASSERT_SAME(a_clamped, v_r[5] && s6_clamp_r, (s6_nv_r <= s6_lim_r) && (s6_nv_r >= -s6_lim_r), "clamped velocity outside limit")

endmodule
